// ===== src/lom_pkg.sv =====
// Shared constants and types of the limit order matching block.
package lom_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int PRICE_BITS = 20;
    localparam int QTY_BITS   = 16;
    localparam int ID_BITS    = 32;
    localparam int STAMP_BITS = 63;
    localparam int KIND_BITS  = 3;
    // One command gives at most 64 results, the added report and 63 fills.
    localparam int MAX_FILLS  = 63;
    localparam int FILL_CNT_BITS = $clog2(MAX_FILLS + 1);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ADDED     = 3'd0,
        KIND_CANCELLED = 3'd1,
        KIND_FILL      = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_UNKNOWN   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        SCAN_FREE,
        SCAN_CANCEL,
        SCAN_MATCH
    } t_scan_mode;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_CANCEL = 1'b1
    } t_opcode;

    typedef struct packed {
        logic       load_input;
        logic       scan_start;
        t_scan_mode scan_mode;
        logic       scan_en;
        logic       add_write;
        logic       pend_full;
        logic       pend_cancel;
        logic       fill_calc;
        logic       wr_bid;
        logic       wr_ask;
        logic       emit;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic go_fill;
        logic out_free;
    } t_sts;

endpackage

// ===== src/lom_if.sv =====
// Command and result channel interfaces of the limit order matching block.
interface lom_cmd_if #(
    parameter int PRICE_BITS = lom_pkg::PRICE_BITS,
    parameter int QTY_BITS   = lom_pkg::QTY_BITS
);
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic                           side;
    logic [QTY_BITS-1:0]            quantity;
    logic [PRICE_BITS-1:0]          price_ticks;
    logic [lom_pkg::STAMP_BITS-1:0] stamp;
    logic [lom_pkg::ID_BITS-1:0]    cancel_id;

    modport source (output valid, opcode, side, quantity, price_ticks, stamp, cancel_id,
                    input ready);
    modport sink   (input valid, opcode, side, quantity, price_ticks, stamp, cancel_id,
                    output ready);
endinterface

interface lom_res_if #(
    parameter int PRICE_BITS = lom_pkg::PRICE_BITS,
    parameter int QTY_BITS   = lom_pkg::QTY_BITS
);
    logic                          valid;
    logic                          ready;
    logic [lom_pkg::KIND_BITS-1:0] kind;
    logic [lom_pkg::ID_BITS-1:0]   order_ref;
    logic [lom_pkg::ID_BITS-1:0]   buy_id;
    logic [lom_pkg::ID_BITS-1:0]   sell_id;
    logic [PRICE_BITS-1:0]         fill_price;
    logic [QTY_BITS-1:0]           fill_qty;
    logic                          buy_done;
    logic                          sell_done;
    logic                          last;

    modport source (output valid, kind, order_ref, buy_id, sell_id, fill_price, fill_qty,
                    buy_done, sell_done, last, input ready);
    modport sink   (input valid, kind, order_ref, buy_id, sell_id, fill_price, fill_qty,
                    buy_done, sell_done, last, output ready);
endinterface

// ===== src/limit_order_matching.sv =====
// Top level of the single-symbol limit order book with price-time priority.
//
// Commands arrive on i_cmd (add or cancel) and results leave on o_res, both
// valid/ready channels; a transfer happens when valid and ready are both high.
// One command is worked on at a time; i_cmd.ready is high while the block is idle.
// Every command ends in a result marked last. An add reports its new id, then
// one fill per crossing of the best bid and best ask, up to MAX_FILLS; an add
// to a full book reports only that. Each step walks the order slot RAM one slot
// per cycle through its single read port: a scan finds a free slot or a cancelled
// id, and a match scan locates the best bid and ask before every fill. The fill
// is then settled, both slots are written back, and its result is passed on
// after the next match scan.
// Results are held in an output register; while the receiver stalls the block
// waits with the next result and keeps the book unchanged. The last result may
// still wait there while the next command is taken.
// Reset empties the book and sets the next order id to one; the slot RAM is not
// cleared, as only slots marked occupied are ever used.
module limit_order_matching #(
    parameter int POOL_DEPTH = lom_pkg::POOL_DEPTH,
    parameter int PRICE_BITS = lom_pkg::PRICE_BITS,
    parameter int QTY_BITS   = lom_pkg::QTY_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lom_cmd_if.sink   i_cmd,
    lom_res_if.source o_res
);
    lom_pkg::t_cmd w_cmd;
    lom_pkg::t_sts w_sts;

    lom_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_in_opcode (i_cmd.opcode),
        .i_sts       (w_sts),
        .o_in_ready  (i_cmd.ready),
        .o_cmd       (w_cmd)
    );

    lom_datapath #(
        .POOL_DEPTH (POOL_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_side        (i_cmd.side),
        .i_quantity    (i_cmd.quantity),
        .i_price_ticks (i_cmd.price_ticks),
        .i_stamp       (i_cmd.stamp),
        .i_cancel_id   (i_cmd.cancel_id),
        .o_res         (o_res)
    );
endmodule

// ===== src/lom_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/lom_ctrl.sv =====
// Controller state machine sequencing slot scans, fills and result transfers.
module lom_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_opcode,
    input  lom_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output lom_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_F, ST_SCAN_C, ST_M_START, ST_M_SCAN, ST_M_EMIT,
        ST_FILL, ST_WR_B, ST_WR_A, ST_FINAL
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_input = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    if (i_in_opcode == lom_pkg::OP_CANCEL) begin
                        o_cmd.scan_mode = lom_pkg::SCAN_CANCEL;
                        n_state = ST_SCAN_C;
                    end else begin
                        o_cmd.scan_mode = lom_pkg::SCAN_FREE;
                        n_state = ST_SCAN_F;
                    end
                end
            end
            ST_SCAN_F: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.add_write = 1'b1;
                    n_state = ST_M_START;
                end else if (i_sts.scan_end) begin
                    o_cmd.pend_full = 1'b1;
                    n_state = ST_FINAL;
                end
            end
            ST_SCAN_C: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.hit || i_sts.scan_end) begin
                    o_cmd.pend_cancel = 1'b1;
                    n_state = ST_FINAL;
                end
            end
            ST_M_START: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_mode  = lom_pkg::SCAN_MATCH;
                n_state = ST_M_SCAN;
            end
            ST_M_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = ST_M_EMIT;
                end
            end
            ST_M_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = !i_sts.go_fill;
                    n_state = i_sts.go_fill ? ST_FILL : ST_IDLE;
                end
            end
            ST_FILL: begin
                o_cmd.fill_calc = 1'b1;
                n_state = ST_WR_B;
            end
            ST_WR_B: begin
                o_cmd.wr_bid = 1'b1;
                n_state = ST_WR_A;
            end
            ST_WR_A: begin
                o_cmd.wr_ask = 1'b1;
                n_state = ST_M_START;
            end
            ST_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== src/lom_datapath.sv =====
// Datapath: order slot store, slot scan, best bid and ask tracking, fill and result registers.
module lom_datapath #(
    parameter int POOL_DEPTH = lom_pkg::POOL_DEPTH,
    parameter int PRICE_BITS = lom_pkg::PRICE_BITS,
    parameter int QTY_BITS   = lom_pkg::QTY_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lom_pkg::t_cmd                  i_cmd,
    output lom_pkg::t_sts                  o_sts,
    input  logic                           i_side,
    input  logic [QTY_BITS-1:0]            i_quantity,
    input  logic [PRICE_BITS-1:0]          i_price_ticks,
    input  logic [lom_pkg::STAMP_BITS-1:0] i_stamp,
    input  logic [lom_pkg::ID_BITS-1:0]    i_cancel_id,
    lom_res_if.source                      o_res
);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int PW = AW + 1;
    localparam int IB = lom_pkg::ID_BITS;
    localparam int SB = lom_pkg::STAMP_BITS;
    localparam int WW = 1 + PRICE_BITS + QTY_BITS + SB + IB;
    localparam int FB = lom_pkg::FILL_CNT_BITS;

    // Input latch.
    logic                  r_side;
    logic [QTY_BITS-1:0]   r_qty;
    logic [PRICE_BITS-1:0] r_price;
    logic [SB-1:0]         r_stamp;
    logic [IB-1:0]         r_cid;

    logic [POOL_DEPTH-1:0] r_valid;
    logic [IB-1:0]         r_next_id;
    logic [FB-1:0]         r_fills;

    // Scan pipeline.
    lom_pkg::t_scan_mode r_mode;
    logic [PW-1:0]       r_ptr;
    logic                r_dv;
    logic [AW-1:0]       r_didx;
    logic                r_hit;
    logic [AW-1:0]       r_hit_idx;
    logic                w_issue;

    // Best bid and best ask records.
    logic                  r_b_have, r_a_have;
    logic [AW-1:0]         r_b_idx, r_a_idx;
    logic [PRICE_BITS-1:0] r_b_price, r_a_price;
    logic [IB-1:0]         r_b_age, r_a_age;
    logic [QTY_BITS-1:0]   r_b_rem, r_a_rem;
    logic [SB-1:0]         r_b_stamp, r_a_stamp;
    logic [IB-1:0]         r_b_id, r_a_id;

    // Pending result and output register.
    logic [lom_pkg::KIND_BITS-1:0] r_p_kind, r_o_kind;
    logic [IB-1:0]                 r_p_oid, r_o_oid, r_p_bid, r_o_bid, r_p_sid, r_o_sid;
    logic [PRICE_BITS-1:0]         r_p_px, r_o_px;
    logic [QTY_BITS-1:0]           r_p_q, r_o_q;
    logic                          r_p_bd, r_o_bd, r_p_sd, r_o_sd;
    logic                          r_o_last, r_o_valid;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [WW-1:0]         w_wdata;
    logic [WW-1:0]         w_rdata;

    logic                  w_rd_side;
    logic [PRICE_BITS-1:0] w_rd_price;
    logic [QTY_BITS-1:0]   w_rd_rem;
    logic [SB-1:0]         w_rd_stamp;
    logic [IB-1:0]         w_rd_id;
    logic [IB-1:0]         w_rd_age;
    logic                  w_rd_valid;
    logic                  w_b_better, w_a_better;
    logic                  w_cross;
    logic [QTY_BITS-1:0]   w_q, w_b_left, w_a_left;

    assign w_issue = i_cmd.scan_en && (r_ptr != PW'(POOL_DEPTH)) && !r_hit;

    assign {w_rd_side, w_rd_price, w_rd_rem, w_rd_stamp, w_rd_id} = w_rdata;
    assign w_rd_age   = r_next_id - w_rd_id;
    assign w_rd_valid = r_valid[r_didx];

    assign w_b_better = !r_b_have || (w_rd_price > r_b_price) ||
                        ((w_rd_price == r_b_price) && (w_rd_age > r_b_age));
    assign w_a_better = !r_a_have || (w_rd_price < r_a_price) ||
                        ((w_rd_price == r_a_price) && (w_rd_age > r_a_age));

    assign w_cross  = r_b_have && r_a_have && (r_b_price >= r_a_price);
    assign w_q      = (r_b_rem < r_a_rem) ? r_b_rem : r_a_rem;
    assign w_b_left = r_b_rem - w_q;
    assign w_a_left = r_a_rem - w_q;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_hit_idx;
        w_wdata = {r_side, r_price, r_qty, r_stamp, r_next_id};
        priority if (i_cmd.add_write) begin
            w_we = 1'b1;
        end else if (i_cmd.wr_bid) begin
            w_we    = 1'b1;
            w_waddr = r_b_idx;
            w_wdata = {1'b0, r_b_price, r_b_rem, r_b_stamp, r_b_id};
        end else if (i_cmd.wr_ask) begin
            w_we    = 1'b1;
            w_waddr = r_a_idx;
            w_wdata = {1'b1, r_a_price, r_a_rem, r_a_stamp, r_a_id};
        end
    end

    lom_ram #(.WIDTH(WW), .DEPTH(POOL_DEPTH)) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_next_id <= IB'(1);
            r_fills   <= '0;
            r_ptr     <= '0;
            r_dv      <= 1'b0;
            r_hit     <= 1'b0;
            r_b_have  <= 1'b0;
            r_a_have  <= 1'b0;
            r_o_valid <= 1'b0;
            r_mode    <= lom_pkg::SCAN_FREE;
        end else begin
            // No slot is issued while a scan starts, so this also clears it then.
            r_dv <= w_issue;
            if (i_cmd.scan_start) begin
                r_mode   <= i_cmd.scan_mode;
                r_ptr    <= '0;
                r_hit    <= 1'b0;
                r_b_have <= 1'b0;
                r_a_have <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_ptr <= r_ptr + PW'(1);
                end
                if (r_dv && !r_hit) begin
                    unique case (r_mode)
                        lom_pkg::SCAN_FREE: begin
                            if (!w_rd_valid) begin
                                r_hit <= 1'b1;
                            end
                        end
                        lom_pkg::SCAN_CANCEL: begin
                            if (w_rd_valid && (w_rd_id == r_cid)) begin
                                r_hit <= 1'b1;
                            end
                        end
                        lom_pkg::SCAN_MATCH: begin
                            if (w_rd_valid && !w_rd_side && w_b_better) begin
                                r_b_have <= 1'b1;
                            end
                            if (w_rd_valid && w_rd_side && w_a_better) begin
                                r_a_have <= 1'b1;
                            end
                        end
                        default: r_hit <= 1'b0;
                    endcase
                end
            end

            if (i_cmd.add_write) begin
                r_valid[r_hit_idx] <= 1'b1;
                r_next_id          <= r_next_id + IB'(1);
                r_fills            <= '0;
            end
            if (i_cmd.pend_cancel && r_hit) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
            if (i_cmd.fill_calc) begin
                r_fills <= r_fills + FB'(1);
                if (w_b_left == '0) begin
                    r_valid[r_b_idx] <= 1'b0;
                end
                if (w_a_left == '0) begin
                    r_valid[r_a_idx] <= 1'b0;
                end
            end

            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_input) begin
            r_side  <= i_side;
            r_qty   <= i_quantity;
            r_price <= i_price_ticks;
            r_stamp <= i_stamp;
            r_cid   <= i_cancel_id;
        end
        if (r_dv && !r_hit && !i_cmd.scan_start) begin
            r_hit_idx <= r_didx;
            if (r_mode == lom_pkg::SCAN_MATCH && w_rd_valid) begin
                if (!w_rd_side && w_b_better) begin
                    r_b_idx   <= r_didx;
                    r_b_price <= w_rd_price;
                    r_b_age   <= w_rd_age;
                    r_b_rem   <= w_rd_rem;
                    r_b_stamp <= w_rd_stamp;
                    r_b_id    <= w_rd_id;
                end
                if (w_rd_side && w_a_better) begin
                    r_a_idx   <= r_didx;
                    r_a_price <= w_rd_price;
                    r_a_age   <= w_rd_age;
                    r_a_rem   <= w_rd_rem;
                    r_a_stamp <= w_rd_stamp;
                    r_a_id    <= w_rd_id;
                end
            end
        end
        r_didx <= r_ptr[AW-1:0];

        if (i_cmd.fill_calc) begin
            r_b_rem <= w_b_left;
            r_a_rem <= w_a_left;
        end

        priority if (i_cmd.add_write) begin
            r_p_kind <= lom_pkg::KIND_ADDED;
            r_p_oid  <= r_next_id;
            r_p_bid  <= '0;
            r_p_sid  <= '0;
            r_p_px   <= '0;
            r_p_q    <= '0;
            r_p_bd   <= 1'b0;
            r_p_sd   <= 1'b0;
        end else if (i_cmd.pend_full || i_cmd.pend_cancel) begin
            if (i_cmd.pend_full) begin
                r_p_kind <= lom_pkg::KIND_FULL;
                r_p_oid  <= '0;
            end else begin
                r_p_kind <= r_hit ? lom_pkg::KIND_CANCELLED : lom_pkg::KIND_UNKNOWN;
                r_p_oid  <= r_cid;
            end
            r_p_bid <= '0;
            r_p_sid <= '0;
            r_p_px  <= '0;
            r_p_q   <= '0;
            r_p_bd  <= 1'b0;
            r_p_sd  <= 1'b0;
        end else if (i_cmd.fill_calc) begin
            r_p_kind <= lom_pkg::KIND_FILL;
            r_p_oid  <= '0;
            r_p_bid  <= r_b_id;
            r_p_sid  <= r_a_id;
            // The order with the earlier stamp sets the price; the bid wins a tie.
            r_p_px   <= (r_b_stamp <= r_a_stamp) ? r_b_price : r_a_price;
            r_p_q    <= w_q;
            r_p_bd   <= (w_b_left == '0);
            r_p_sd   <= (w_a_left == '0);
        end

        if (i_cmd.emit) begin
            r_o_kind <= r_p_kind;
            r_o_oid  <= r_p_oid;
            r_o_bid  <= r_p_bid;
            r_o_sid  <= r_p_sid;
            r_o_px   <= r_p_px;
            r_o_q    <= r_p_q;
            r_o_bd   <= r_p_bd;
            r_o_sd   <= r_p_sd;
            r_o_last <= i_cmd.emit_last;
        end
    end

    assign o_sts.hit      = r_hit;
    assign o_sts.scan_end = (r_ptr == PW'(POOL_DEPTH)) && !r_dv;
    assign o_sts.go_fill  = w_cross && (r_fills != FB'(lom_pkg::MAX_FILLS));
    assign o_sts.out_free = !r_o_valid || o_res.ready;

    assign o_res.valid      = r_o_valid;
    assign o_res.kind       = r_o_kind;
    assign o_res.order_ref  = r_o_oid;
    assign o_res.buy_id     = r_o_bid;
    assign o_res.sell_id    = r_o_sid;
    assign o_res.fill_price = r_o_px;
    assign o_res.fill_qty   = r_o_q;
    assign o_res.buy_done   = r_o_bd;
    assign o_res.sell_done  = r_o_sd;
    assign o_res.last       = r_o_last;
endmodule

// ===== src/lom_checker.sv =====
// Port-level checker of the limit order matching block and its bind statement.
module lom_checker #(
    parameter int PRICE_BITS = lom_pkg::PRICE_BITS,
    parameter int QTY_BITS   = lom_pkg::QTY_BITS
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [lom_pkg::KIND_BITS-1:0] i_out_kind,
    input logic [lom_pkg::ID_BITS-1:0]   i_out_order_ref,
    input logic [lom_pkg::ID_BITS-1:0]   i_out_buy_id,
    input logic [lom_pkg::ID_BITS-1:0]   i_out_sell_id,
    input logic [QTY_BITS-1:0]           i_out_fill_qty,
    input logic [PRICE_BITS-1:0]         i_out_fill_price,
    input logic                          i_out_buy_done,
    input logic                          i_out_sell_done,
    input logic                          i_out_last
);
    // Commands taken whose last result has not yet been transferred; a new command
    // may be taken while the previous last result still waits, so this reaches two.
    logic [1:0] r_inflight;
    logic       w_in_xfer;
    logic       w_last_xfer;

    assign w_in_xfer   = i_in_valid && i_in_ready;
    assign w_last_xfer = i_out_valid && i_out_ready && i_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 2'd0;
        end else if (w_in_xfer && !w_last_xfer) begin
            r_inflight <= r_inflight + 2'd1;
        end else if (!w_in_xfer && w_last_xfer) begin
            r_inflight <= r_inflight - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) &&
        $stable(i_out_last) && $stable(i_out_fill_qty) && $stable(i_out_order_ref))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != 2'd0)
        else $error("result shown with no command outstanding");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |->
        r_inflight == 2'd0 || (r_inflight == 2'd1 && i_out_valid && i_out_last))
        else $error("command taken before the previous one finished");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |->
        i_out_kind == lom_pkg::KIND_ADDED || i_out_kind == lom_pkg::KIND_FILL)
        else $error("only an add report or a fill can be followed by more results");

    a_fill_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != lom_pkg::KIND_FILL |->
        i_out_buy_id == '0 && i_out_sell_id == '0 && i_out_fill_qty == '0 &&
        i_out_fill_price == '0 && !i_out_buy_done && !i_out_sell_done)
        else $error("fill fields set on a result that is not a fill");
endmodule

bind limit_order_matching lom_checker #(
    .PRICE_BITS (PRICE_BITS),
    .QTY_BITS   (QTY_BITS)
) u_lom_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_cmd.valid),
    .i_in_ready       (i_cmd.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_out_kind       (o_res.kind),
    .i_out_order_ref  (o_res.order_ref),
    .i_out_buy_id     (o_res.buy_id),
    .i_out_sell_id    (o_res.sell_id),
    .i_out_fill_qty   (o_res.fill_qty),
    .i_out_fill_price (o_res.fill_price),
    .i_out_buy_done   (o_res.buy_done),
    .i_out_sell_done  (o_res.sell_done),
    .i_out_last       (o_res.last)
);
